@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Assertion that is also checked across reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/twu_pkg.sv @@
`timescale 1ns / 1ps

package twu_pkg;

  localparam int NUM_TASKS = 32;
  localparam int SLOT_W    = $clog2(NUM_TASKS);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_TIME  = 2'd1;
  localparam logic [1:0] REQ_DELAY = 2'd2;
  localparam logic [1:0] REQ_UNTIL = 2'd3;

  localparam logic KIND_WAKE = 1'b0;
  localparam logic KIND_TIME = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  task_id;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic        reply_kind;
    logic [4:0]  dest_task;
    logic [31:0] time_value;
    logic        is_last;
  } reply_t;

  typedef struct packed {
    logic        armed;
    logic [31:0] wake_time;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

@@ rtl/twu_cell.sv @@
`timescale 1ns / 1ps

module twu_cell import twu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctl_t   ctl,
  input  slot_t       shift_in,
  input  logic [31:0] wr_time,
  input  logic [31:0] tick_count,
  output slot_t       slot,
  output logic        due
);

  logic        armed;
  logic [31:0] wake_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
    end else if (ctl.wr) begin
      armed <= 1'b1;
    end else if (ctl.shift) begin
      armed <= shift_in.armed;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      wake_time <= wr_time;
    end else if (ctl.shift) begin
      wake_time <= shift_in.wake_time;
    end
  end

  assign slot.armed     = armed;
  assign slot.wake_time = wake_time;
  assign due            = armed && (wake_time <= tick_count);

endmodule

@@ rtl/task_wakeup_timer_unit.sv @@
`timescale 1ns / 1ps
// Task wakeup timer: a tick counter and one alarm slot per task.
// The req channel takes one request per transfer: a tick, a time query,
// a relative delay or a delay until an absolute time. The reply channel
// returns wake notices and time answers, one per transfer, with is_last set
// on the final reply that a request causes; a request may cause none.
// The slots sit in a ring of NUM_TASKS cells that rotates by one position
// each scan step, so the head cell sees the slots in ascending order and one
// comparison per cycle decides whether that slot wakes, unless a due slot stalls.
// A request runs a scan of all NUM_TASKS slots and then an apply state; the
// block accepts the next request only once it is back in idle, so it takes
// no new request before it is through with the last one (req_ready is low).
// Replies pass through an output register; while it is full and not taken,
// the scan holds on any slot that is due, so a stalled receiver only delays
// the request. Reset clears the counter, disarms every slot and empties the
// output register; the block is ready in the first cycle after reset.
module task_wakeup_timer_unit import twu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_ready,
  input  req_t   req,
  output logic   reply_valid,
  input  logic   reply_ready,
  output reply_t reply
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]        state;
  logic [SLOT_W-1:0] scan_cnt;
  logic [31:0]       tick_count;
  req_t              cur;

  slot_t             slots [NUM_TASKS];
  logic [NUM_TASKS-1:0] due_vec;
  cell_ctl_t         ctls  [NUM_TASKS];

  logic        can_emit;
  logic        head_due;
  logic        others_due;
  logic        step;
  logic        emit_wake;
  logic        emit_time;
  logic        do_write;
  logic [31:0] wr_time;
  logic [31:0] idx_wide;
  slot_t       tail_in;

  assign req_ready  = (state == ST_IDLE);
  assign can_emit   = !reply_valid || reply_ready;
  assign head_due   = due_vec[0];
  assign others_due = |due_vec[NUM_TASKS-1:1];
  assign step       = (state == ST_SCAN) && (!head_due || can_emit);
  assign emit_wake  = step && head_due;
  assign emit_time  = (state == ST_APPLY) && (cur.req_type == REQ_TIME) && can_emit;
  assign do_write   = (state == ST_APPLY)
                      && ((cur.req_type == REQ_DELAY) || (cur.req_type == REQ_UNTIL))
                      && (int'(cur.task_id) < NUM_TASKS);
  assign wr_time    = (cur.req_type == REQ_DELAY) ? tick_count + cur.amount : cur.amount;
  assign idx_wide   = 32'(scan_cnt);

  always_comb begin
    tail_in       = slots[0];
    tail_in.armed = slots[0].armed && !emit_wake;
  end

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    assign ctls[i].shift = step;
    assign ctls[i].wr    = do_write && (int'(cur.task_id) == i);

    twu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctls[i]),
      .shift_in   ((i == NUM_TASKS - 1) ? tail_in : slots[(i + 1) % NUM_TASKS]),
      .wr_time    (wr_time),
      .tick_count (tick_count),
      .slot       (slots[i]),
      .due        (due_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_cnt   <= '0;
      tick_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (scan_cnt == SLOT_W'(NUM_TASKS - 1)) begin
              state <= ST_APPLY;
            end
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_APPLY: begin
          if (cur.req_type == REQ_TICK) begin
            tick_count <= tick_count + 32'd1;
            state      <= ST_IDLE;
          end else if (cur.req_type == REQ_TIME) begin
            if (can_emit) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (emit_wake || emit_time) begin
      reply_valid <= 1'b1;
    end else if (reply_ready) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_wake) begin
      reply.reply_kind <= KIND_WAKE;
      reply.dest_task  <= idx_wide[4:0];
      reply.time_value <= tick_count;
      reply.is_last    <= !others_due && (cur.req_type != REQ_TIME);
    end else if (emit_time) begin
      reply.reply_kind <= KIND_TIME;
      reply.dest_task  <= cur.task_id;
      reply.time_value <= tick_count;
      reply.is_last    <= 1'b1;
    end
  end

endmodule

@@ rtl/twu_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twu_checker import twu_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   req_valid,
  input logic   req_ready,
  input req_t   req,
  input logic   reply_valid,
  input logic   reply_ready,
  input reply_t reply
);

  `ASSERT_RUN(a_req_hold, clk, rst, req_valid && !req_ready |=> req_valid && $stable(req))
  `ASSERT_RUN(a_reply_hold, clk, rst, reply_valid && !reply_ready |=> reply_valid && $stable(reply))
  `ASSERT_RUN(a_busy_after_req, clk, rst, req_valid && req_ready |=> !req_ready)
  `ASSERT_RUN(a_time_is_last, clk, rst, reply_valid && (reply.reply_kind == KIND_TIME) |-> reply.is_last)
  `ASSERT_ALWAYS(a_reset_state, clk, $past(rst) |-> !reply_valid && req_ready)

endmodule

bind task_wakeup_timer_unit twu_checker u_twu_checker (.*);
